// File: rtl/core/sprq_pkg.sv
package sprq_pkg;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_PEEK   = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef logic        [1:0]  mode_type;
   typedef logic signed [31:0] value_type;
   typedef logic signed [15:0] prio_type;
   typedef logic        [1:0]  status_type;
   typedef logic        [4:0]  occ_type;

   typedef struct packed {
      logic load_req;
      logic scan_read;
      logic shift_write;
      logic place_write;
      logic take_head;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic go_scan;
      logic go_head;
      logic cur_zero;
      logic rd_greater;
   } sts_type;

endpackage

// File: rtl/core/sprq_if.sv
interface sprq_req_if;
   import sprq_pkg::*;

   logic      valid;
   logic      ready;
   mode_type  mode;
   value_type item_value;
   prio_type  item_priority;

   modport source (output valid, output mode, output item_value, output item_priority,
                   input ready);
   modport sink (input valid, input mode, input item_value, input item_priority,
                 output ready);
endinterface

interface sprq_rsp_if;
   import sprq_pkg::*;

   logic       valid;
   logic       ready;
   value_type  head_value;
   status_type status;
   occ_type    occupancy;

   modport source (output valid, output head_value, output status, output occupancy,
                   input ready);
   modport sink (input valid, input head_value, input status, input occupancy,
                 output ready);
endinterface

// File: rtl/core/sorted_priority_queue_core.sv
// Bounded priority queue kept sorted by ascending priority number (lower number leaves
// first, equal numbers in arrival order), held in a circular memory of CAPACITY entries
// with one write and one registered read port. One operation word is taken at a time
// and answered by one word. Delete and peek read the head before they respond; a refused
// insert, an empty delete/peek or the unused mode code respond without a memory access.
// An insert walks back from the tail, reading each stored entry with a larger priority
// number through the memory's registered read port and moving it up one place, then
// writes the new entry into the freed slot. Occupancy is reported modulo 32.
module sorted_priority_queue_core #(
   parameter int CAPACITY = 16
) (
   input logic         clock,
   input logic         reset,
   sprq_req_if.sink    req_ch,
   sprq_rsp_if.source  rsp_ch
);
   import sprq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   sprq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   sprq_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_mode   (req_ch.mode),
      .req_value  (req_ch.item_value),
      .req_prio   (req_ch.item_priority),
      .rsp_value  (rsp_ch.head_value),
      .rsp_status (rsp_ch.status),
      .rsp_occ    (rsp_ch.occupancy)
   );

endmodule

// File: rtl/core/sprq_ctrl.sv
module sprq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   input  sprq_pkg::sts_type sts,
   output sprq_pkg::cmd_type cmd
);
   import sprq_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_CMP  = 3'd2;
   localparam logic [2:0] S_HEAD = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (sts.go_scan) begin
                  state_in = S_SCAN;
               end else if (sts.go_head) begin
                  state_in = S_HEAD;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_SCAN: begin
            if (sts.cur_zero) begin
               cmd.place_write = 1'b1;
               state_in        = S_FIN;
            end else begin
               cmd.scan_read = 1'b1;
               state_in      = S_CMP;
            end
         end
         S_CMP: begin
            if (sts.rd_greater) begin
               cmd.shift_write = 1'b1;
               state_in        = S_SCAN;
            end else begin
               cmd.place_write = 1'b1;
               state_in        = S_FIN;
            end
         end
         S_HEAD: begin
            cmd.take_head = 1'b1;
            state_in      = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.shift_write, cmd.place_write, cmd.take_head}))
      else $error("overlapping datapath writes");

   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid)
      else $error("word loaded but not presented");

endmodule

// File: rtl/core/sprq_dpath.sv
module sprq_dpath #(
   parameter int CAPACITY = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sprq_pkg::cmd_type    cmd,
   output sprq_pkg::sts_type    sts,
   input  sprq_pkg::mode_type   req_mode,
   input  sprq_pkg::value_type  req_value,
   input  sprq_pkg::prio_type   req_prio,
   output sprq_pkg::value_type  rsp_value,
   output sprq_pkg::status_type rsp_status,
   output sprq_pkg::occ_type    rsp_occ
);
   import sprq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [AW:0]   CAP_W   = (AW + 1)'(CAPACITY);
   localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
   localparam logic [AW-1:0] HD_LAST = AW'(CAPACITY - 1);

   value_type mem_value [CAPACITY];
   prio_type  mem_prio  [CAPACITY];

   logic [CW-1:0] count_ff;
   logic [AW-1:0] hd_ff;
   logic [CW-1:0] cur_ff;
   value_type     new_value_ff;
   prio_type      new_prio_ff;
   logic          del_ff;
   value_type     rd_value_ff;
   prio_type      rd_prio_ff;
   value_type     res_value_ff;
   status_type    res_status_ff;
   value_type     head_value_ff;
   status_type    status_ff;
   occ_type       occ_ff;

   logic          full;
   logic          empty;
   logic          req_insert;
   logic          req_head;
   logic [CW-1:0] cur_dec;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic          wr_en;
   value_type     wr_value;
   prio_type      wr_prio;
   status_type    req_status;

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= CAP_W) begin
         sum = sum - CAP_W;
      end
      return sum[AW-1:0];
   endfunction

   assign full       = (count_ff == CAP_C);
   assign empty      = (count_ff == '0);
   assign req_insert = (req_mode == MODE_INSERT);
   assign req_head   = (req_mode == MODE_DELETE) || (req_mode == MODE_PEEK);
   assign cur_dec    = cur_ff - 1'b1;

   assign sts.go_scan    = req_insert && !full;
   assign sts.go_head    = req_head && !empty;
   assign sts.cur_zero   = (cur_ff == '0);
   assign sts.rd_greater = (rd_prio_ff > new_prio_ff);

   always_comb begin
      if (req_insert && full) begin
         req_status = STAT_FULL;
      end else if (req_head && empty) begin
         req_status = STAT_EMPTY;
      end else begin
         req_status = STAT_OK;
      end
   end

   assign rd_addr  = cmd.scan_read ? phys(hd_ff, cur_dec[AW-1:0]) : hd_ff;
   assign wr_addr  = phys(hd_ff, cur_ff[AW-1:0]);
   assign wr_en    = cmd.shift_write || cmd.place_write;
   assign wr_value = cmd.shift_write ? rd_value_ff : new_value_ff;
   assign wr_prio  = cmd.shift_write ? rd_prio_ff : new_prio_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_value[wr_addr] <= wr_value;
         mem_prio[wr_addr]  <= wr_prio;
      end
      rd_value_ff <= mem_value[rd_addr];
      rd_prio_ff  <= mem_prio[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         hd_ff    <= '0;
      end else begin
         if (cmd.place_write) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.take_head && del_ff) begin
            count_ff <= count_ff - 1'b1;
            hd_ff    <= (hd_ff == HD_LAST) ? '0 : hd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         new_value_ff  <= req_value;
         new_prio_ff   <= req_prio;
         del_ff        <= (req_mode == MODE_DELETE);
         cur_ff        <= count_ff;
         res_value_ff  <= '0;
         res_status_ff <= req_status;
      end
      if (cmd.shift_write) begin
         cur_ff <= cur_dec;
      end
      if (cmd.take_head) begin
         res_value_ff <= rd_value_ff;
      end
      if (cmd.load_rsp) begin
         head_value_ff <= res_value_ff;
         status_ff     <= res_status_ff;
         occ_ff        <= 5'(count_ff);
      end
   end

   assign rsp_value  = head_value_ff;
   assign rsp_status = status_ff;
   assign rsp_occ    = occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("count above capacity");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.place_write |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not advance count");

   a_head_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.take_head |-> count_ff != '0)
      else $error("head taken from empty queue");

endmodule
